// File: rtl/core/sorted_insert_list_macros.svh
// Assertion macros for the sorted insert list checker.
// Depends on a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef SORTED_INSERT_LIST_MACROS_SVH
`define SORTED_INSERT_LIST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SIL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted_insert_list: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SIL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted_insert_list: next-cycle check failed");

`endif

// File: rtl/core/sil_pkg.sv
// Shared types and constants for the sorted insert list.
// No dependencies.
`default_nettype none

package sil_pkg;

    localparam int DEPTH     = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 7;
    localparam int IDX_W     = 6;
    localparam int ENTRY_W   = 7;
    localparam int DATA_W    = 32;
    localparam int CMP_W0    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CMP_W     = (CMP_W0 > IDX_W) ? CMP_W0 : IDX_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] new_value;
        logic [IDX_W-1:0]         read_index;
    } t_req;

    typedef struct packed {
        logic                     accepted;
        logic signed [DATA_W-1:0] read_value;
        logic                     read_valid;
        logic [ENTRY_W-1:0]       entry_count;
    } t_rsp;

    typedef enum logic [1:0] {
        FIN_NONE,
        FIN_INS_OK,
        FIN_INS_REJ,
        FIN_READ
    } t_fin;

    typedef struct packed {
        logic load;
        logic init_pos;
        logic issue_rd;
        logic shift;
        logic place;
        t_fin fin;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic can_insert;
        logic rd_in_range;
        logic pos_zero;
        logic go_shift;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/core/sil_datapath.sv
// Datapath: entry memory, count, capacity register, insert position and result register.
// Depends on sil_pkg.
`default_nettype none

module sil_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sil_pkg::t_req    i_req,
    input  wire logic             i_cfg_we,
    input  wire logic [6:0]       i_cfg_wdata,
    input  wire sil_pkg::t_cmd    i_cmd,
    output sil_pkg::t_stat        o_stat,
    output logic                  o_rsp_valid,
    output sil_pkg::t_rsp         o_rsp
);
    import sil_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;
    t_req                     r_req;
    logic [CNT_W-1:0]         r_count;
    logic [CAP_W-1:0]         r_cap;
    logic [ADDR_W-1:0]        r_pos;
    logic                     r_rsp_valid;
    t_rsp                     r_rsp;

    logic [ADDR_W-1:0]        rd_addr;
    logic                     mem_we;
    logic signed [DATA_W-1:0] mem_wdata;
    t_rsp                     n_rsp;

    always_comb begin
        o_stat.is_read     = (r_req.req_type == REQ_READ);
        o_stat.can_insert  = (CMP_W'(r_count) < CMP_W'(r_cap))
                             && (r_count < CNT_W'(DEPTH));
        o_stat.rd_in_range = CMP_W'(r_req.read_index) < CMP_W'(r_count);
        o_stat.pos_zero    = (r_pos == '0);
        o_stat.go_shift    = (r_req.new_value < r_rd_data);
    end

    always_comb begin
        if (r_req.req_type == REQ_READ) begin
            rd_addr = ADDR_W'(r_req.read_index);
        end else begin
            rd_addr = r_pos - ADDR_W'(1);
        end
        mem_we    = i_cmd.shift || i_cmd.place;
        mem_wdata = i_cmd.shift ? r_rd_data : r_req.new_value;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_pos] <= mem_wdata;
        end
        if (i_cmd.issue_rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.init_pos) begin
            r_pos <= ADDR_W'(r_count);
        end else if (i_cmd.shift) begin
            r_pos <= r_pos - ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.place) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_rsp             = '0;
        n_rsp.entry_count = ENTRY_W'(r_count);
        unique case (i_cmd.fin)
            FIN_INS_OK: begin
                n_rsp.accepted = 1'b1;
            end
            FIN_READ: begin
                n_rsp.read_valid = o_stat.rd_in_range;
                n_rsp.read_value = o_stat.rd_in_range ? r_rd_data : '0;
            end
            default: begin
                n_rsp.accepted = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= (i_cmd.fin != FIN_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin != FIN_NONE) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire

// File: rtl/core/sil_ctrl.sv
// Controller state machine: sequences decode, reads, top-down shift search, placement and result.
// Depends on sil_pkg.
`default_nettype none

module sil_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire sil_pkg::t_stat i_stat,
    output sil_pkg::t_cmd       o_cmd
);
    import sil_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH,
        ST_CMP,
        ST_PLACED,
        ST_RD_WAIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.fin = FIN_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_stat.is_read) begin
                    if (i_stat.rd_in_range) begin
                        o_cmd.issue_rd = 1'b1;
                        n_state        = ST_RD_WAIT;
                    end else begin
                        o_cmd.fin = FIN_READ;
                        n_state   = ST_IDLE;
                    end
                end else if (!i_stat.can_insert) begin
                    o_cmd.fin = FIN_INS_REJ;
                    n_state   = ST_IDLE;
                end else begin
                    o_cmd.init_pos = 1'b1;
                    n_state        = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_stat.pos_zero) begin
                    o_cmd.place = 1'b1;
                    n_state     = ST_PLACED;
                end else begin
                    o_cmd.issue_rd = 1'b1;
                    n_state        = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_stat.go_shift) begin
                    o_cmd.shift = 1'b1;
                    n_state     = ST_SEARCH;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = ST_PLACED;
                end
            end
            ST_PLACED: begin
                o_cmd.fin = FIN_INS_OK;
                n_state   = ST_IDLE;
            end
            ST_RD_WAIT: begin
                o_cmd.fin = FIN_READ;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_busy = (n_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy = r_busy;

endmodule

`default_nettype wire

// File: rtl/core/sorted_insert_list.sv
// Sorted insert list: ascending list of signed 32-bit values with count and capacity.
// A read goes through decode, a registered memory read and the result; an out-of-range read and a
// refused insert finish from decode. An insert reads and moves up each larger entry, then places it.
// The top-down compare-and-move loop over the single-port entry memory sets the insert time.
// busy falls with the strobe, so the next item may start in the strobe cycle.
// Synchronous reset clears count and state, sets capacity to 64; entries are not cleared.
`default_nettype none

module sorted_insert_list (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire sil_pkg::t_req i_req,
    input  wire logic          i_cfg_we,
    input  wire logic [6:0]    i_cfg_wdata,
    output logic               o_rsp_valid,
    output sil_pkg::t_rsp      o_rsp
);
    import sil_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sil_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    sil_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

// File: rtl/core/sil_checker.sv
// Port-level checker for the sorted insert list, bound to the top level.
// Depends on sil_pkg and sorted_insert_list_macros.svh.
`default_nettype none

`include "sorted_insert_list_macros.svh"

module sil_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          o_rsp_valid,
    input wire sil_pkg::t_rsp o_rsp
);
    import sil_pkg::*;

    `SIL_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
    `SIL_ASSERT_NOW(a_idle_on_strobe, o_rsp_valid, !busy)
    `SIL_ASSERT_NEXT(a_single_strobe, o_rsp_valid, !o_rsp_valid)
    `SIL_ASSERT_NOW(a_no_accept_on_read, o_rsp_valid, !(o_rsp.accepted && o_rsp.read_valid))
    `SIL_ASSERT_NOW(a_invalid_reads_zero, o_rsp_valid && !o_rsp.read_valid, o_rsp.read_value == 0)

endmodule

bind sorted_insert_list sil_checker u_sil_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_rsp_valid (o_rsp_valid),
    .o_rsp       (o_rsp)
);

`default_nettype wire
